// ===== src/mahp_pkg.sv =====
// ----------------------------------------------------------------------------
// mahp_pkg
// Shared types, register codes and helpers of the moving average high-pass
// filter.
// ----------------------------------------------------------------------------
package mahp_pkg;

  localparam int MAHP_SIZE = 512;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 17;

  localparam logic [CFG_IW-1:0] CFG_FEED_LEVEL     = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FEED_MOD_DEPTH = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WET_MIX        = 2'd2;

  // 180 degrees in Q8.16.
  localparam logic [23:0] WINDOW_NUM = 24'd11796480;
  localparam int          MIN_LEN    = 2;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic        [23:0] cutoff_step;
    logic signed [15:0] feedback_in;
    logic signed [15:0] feedback_mod;
  } mahp_in_t;

  typedef struct packed {
    logic signed [15:0] mixed_out;
    logic signed [15:0] wet_out;
  } mahp_out_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_WALK,
    B_DIV,
    B_AVG,
    B_INNER,
    B_GLO,
    B_GHI,
    B_FB,
    B_MIXA,
    B_MIXB,
    B_WRITE
  } back_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== src/mahp_ram.sv =====
// ----------------------------------------------------------------------------
// mahp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mahp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== src/mahp_front.sv =====
// ----------------------------------------------------------------------------
// mahp_front
// Accepts input requests and works out the window length with a
// bit-serial divider, then hands the job to the queue.
// ----------------------------------------------------------------------------
module mahp_front #(
  parameter int SIZE = mahp_pkg::MAHP_SIZE,
  parameter int LW   = $clog2(SIZE + 1),
  parameter int JW   = 48 + LW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  mahp_pkg::mahp_in_t in_data,
  output logic               in_full,
  input  logic               clearing,
  output logic               q_push,
  output logic [JW-1:0]      q_data,
  input  logic               q_full
);
  import mahp_pkg::*;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic signed [15:0] feedback_in;
    logic signed [15:0] feedback_mod;
    logic [LW-1:0]      len;
  } job_t;

  front_state_t state_r, state_nxt;
  mahp_in_t     item_r;
  logic [24:0]  rem_r;
  logic [23:0]  quo_r;
  logic [4:0]   cnt_r;
  logic [24:0]  shifted;
  logic         ge;
  logic [LW-1:0] len;
  job_t         job;

  assign shifted = {rem_r[23:0], quo_r[23]};
  assign ge      = shifted >= {1'b0, item_r.cutoff_step};

  always_comb begin
    if (item_r.cutoff_step == 24'd0) begin
      len = LW'(SIZE - 1);
    end else if (quo_r < 24'(MIN_LEN)) begin
      len = LW'(MIN_LEN);
    end else if (quo_r > 24'(SIZE)) begin
      len = LW'(SIZE - 1);
    end else begin
      len = quo_r[LW-1:0];
    end
  end

  always_comb begin
    job.sample_in    = item_r.sample_in;
    job.feedback_in  = item_r.feedback_in;
    job.feedback_mod = item_r.feedback_mod;
    job.len          = len;
  end
  assign q_data = job;

  always_comb begin
    state_nxt = state_r;
    in_full   = 1'b1;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_full = clearing;
        if (in_push && !clearing) begin
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        if (cnt_r == 5'd23) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE) begin
      item_r <= in_data;
      rem_r  <= '0;
      quo_r  <= WINDOW_NUM;
      cnt_r  <= '0;
    end else if (state_r == F_DIV) begin
      rem_r <= ge ? shifted - {1'b0, item_r.cutoff_step} : shifted;
      quo_r <= {quo_r[22:0], ge};
      cnt_r <= cnt_r + 5'd1;
    end
  end

endmodule

// ===== src/mahp_queue.sv =====
// ----------------------------------------------------------------------------
// mahp_queue
// Two entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module mahp_queue #(
  parameter int W = 58
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wptr_r, rptr_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== src/mahp_back.sv =====
// ----------------------------------------------------------------------------
// mahp_back
// Walks the filter ring window, divides the sum, forms gain, wet and mix,
// updates both rings and holds the result register.
// ----------------------------------------------------------------------------
module mahp_back #(
  parameter int SIZE = mahp_pkg::MAHP_SIZE,
  parameter int LW   = $clog2(SIZE + 1),
  parameter int JW   = 48 + LW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mahp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mahp_pkg::CFG_DW-1:0] cfg_data,
  input  logic                        q_empty,
  input  logic [JW-1:0]               q_data,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_empty,
  input  logic                        out_pop,
  output mahp_pkg::mahp_out_t         out_data
);
  import mahp_pkg::*;

  localparam int AW  = $clog2(SIZE);
  localparam int SW  = 16 + LW;
  localparam int DCW = $clog2(SW);

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic signed [15:0] feedback_in;
    logic signed [15:0] feedback_mod;
    logic [LW-1:0]      len;
  } job_t;

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [AW-1:0] pos_r, clr_r, addr_r;
  logic [LW-1:0] issued_r;
  logic          rdv_r;
  logic signed [SW-1:0] sum_r;
  logic [LW:0]   rem_r;
  logic [SW-1:0] quo_r;
  logic [DCW-1:0] dcnt_r;
  logic          neg_r;
  logic signed [15:0] wet_r, fval_r, mix_r;
  logic signed [33:0] inner_r, plo_r;
  logic signed [19:0] gain_r;
  logic signed [33:0] ma_r;
  logic signed [16:0] feed_level_r;
  logic [15:0]   depth_r, wet_mix_r;
  logic          out_valid_r;
  mahp_out_t     out_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   src_wdata, flt_wdata, src_rdata, flt_rdata;
  logic          issue, out_free, div_ge;
  logic [LW:0]   div_sh;
  logic [SW-1:0] sum_mag;
  logic signed [SW-1:0] avg;
  logic signed [32:0] dm;
  logic signed [17:0] depth_ofs, mix_ofs;
  logic signed [33:0] inner_nxt;
  logic signed [34:0] phi;
  logic signed [51:0] pfull, gfull;
  logic signed [35:0] fbp;
  logic signed [32:0] mb;
  logic signed [34:0] msum;

  mahp_ram #(.WIDTH(16), .DEPTH(SIZE)) u_src_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(src_wdata),
    .raddr(pos_r),
    .rdata(src_rdata)
  );

  mahp_ram #(.WIDTH(16), .DEPTH(SIZE)) u_flt_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(flt_wdata),
    .raddr(addr_r),
    .rdata(flt_rdata)
  );

  assign clearing  = state_r == B_CLEAR;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_pop;
  assign issue     = issued_r != job_r.len;

  assign div_sh  = {rem_r[LW-1:0], quo_r[SW-1]};
  assign div_ge  = div_sh >= {1'b0, job_r.len};
  assign sum_mag = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign avg     = neg_r ? -$signed(quo_r) : $signed(quo_r);

  assign dm        = $signed({1'b0, depth_r}) * job_r.feedback_mod;
  assign depth_ofs = 18'sd32768 - $signed({2'b00, depth_r});
  assign inner_nxt = (34'(depth_ofs) <<< 15) + 34'(dm);
  assign phi       = feed_level_r * $signed(inner_r[33:16]);
  assign pfull     = (52'(phi) <<< 16) + 52'(plo_r);
  assign gfull     = (pfull + 52'sd536870912) >>> 30;
  assign fbp       = job_r.feedback_in * gain_r;
  assign mix_ofs   = 18'sd32768 - $signed({2'b00, wet_mix_r});
  assign mb        = wet_r * $signed({1'b0, wet_mix_r});
  assign msum      = (35'(ma_r) + 35'(mb) + 35'sd16384) >>> 15;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    src_wdata = job_r.sample_in;
    flt_wdata = fval_r;
    case (state_r)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        src_wdata = '0;
        flt_wdata = '0;
        if (clr_r == AW'(SIZE - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_WALK;
        end
      end
      B_WALK: begin
        if (!issue && !rdv_r) begin
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (dcnt_r == DCW'(SW - 1)) begin
          state_nxt = B_AVG;
        end
      end
      B_AVG:   state_nxt = B_INNER;
      B_INNER: state_nxt = B_GLO;
      B_GLO:   state_nxt = B_GHI;
      B_GHI:   state_nxt = B_FB;
      B_FB:    state_nxt = B_MIXA;
      B_MIXA:  state_nxt = B_MIXB;
      B_MIXB:  state_nxt = B_WRITE;
      B_WRITE: begin
        ram_we = 1'b1;
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_CLEAR;
      clr_r        <= '0;
      pos_r        <= AW'(SIZE - 1);
      out_valid_r  <= 1'b0;
      feed_level_r <= '0;
      depth_r      <= '0;
      wet_mix_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FEED_LEVEL:     feed_level_r <= $signed(cfg_data);
          CFG_FEED_MOD_DEPTH: depth_r      <= cfg_data[15:0];
          CFG_WET_MIX:        wet_mix_r    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state_r == B_WRITE && out_free) begin
        out_valid_r <= 1'b1;
        pos_r       <= (pos_r == '0) ? AW'(SIZE - 1) : pos_r - AW'(1);
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        job_r    <= job_t'(q_data);
        addr_r   <= pos_r;
        issued_r <= '0;
        rdv_r    <= 1'b0;
        sum_r    <= '0;
      end
      B_WALK: begin
        rdv_r <= issue;
        if (issue) begin
          addr_r   <= (addr_r == AW'(SIZE - 1)) ? '0 : addr_r + AW'(1);
          issued_r <= issued_r + LW'(1);
        end
        if (rdv_r) begin
          sum_r <= sum_r + SW'($signed(flt_rdata));
        end
        neg_r  <= sum_r[SW-1];
        quo_r  <= sum_mag;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      B_DIV: begin
        rem_r  <= div_ge ? div_sh - {1'b0, job_r.len} : div_sh;
        quo_r  <= {quo_r[SW-2:0], div_ge};
        dcnt_r <= dcnt_r + DCW'(1);
      end
      B_AVG:   wet_r   <= sat16(48'(avg) - 48'($signed(src_rdata)));
      B_INNER: inner_r <= inner_nxt;
      B_GLO:   plo_r   <= 34'(feed_level_r * $signed({1'b0, inner_r[15:0]}));
      B_GHI:   gain_r  <= gfull[19:0];
      B_FB:    fval_r  <= sat16(48'(job_r.sample_in) + (48'(fbp + 36'sd16384) >>> 15));
      B_MIXA:  ma_r    <= 34'(job_r.sample_in * mix_ofs);
      B_MIXB:  mix_r   <= sat16(48'(msum));
      B_WRITE: begin
        if (out_free) begin
          out_r.mixed_out <= mix_r;
          out_r.wet_out   <= wet_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/moving_average_highpass_filter.sv =====
// ----------------------------------------------------------------------------
// moving_average_highpass_filter
// Moving average high-pass filter with feedback, Q1.15 fixed point.
//
//   channel  ports                          width        accepted when
//   input    in_push, in_data, in_full      mahp_in_t    in_push && !in_full
//   result   out_pop, out_data, out_empty   mahp_out_t   out_pop && !out_empty
//   config   cfg_we, cfg_index, cfg_data    17 bit data  cfg_we
//
// The front works out each request's length with a bit-serial divider and
// takes no new request until it has pushed the job into the queue. The back
// walks the window through the filter ring read port, then runs the bit-serial
// average divider and the gain, wet and mix steps; front and back overlap through the queue.
// After reset a clearing pass zeroes both rings; in_full is high meanwhile.
// A result waiting in the output register stalls the back only at ring update.
// ----------------------------------------------------------------------------
module moving_average_highpass_filter #(
  parameter int SIZE = mahp_pkg::MAHP_SIZE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  mahp_pkg::mahp_in_t          in_data,
  output logic                        in_full,
  output logic                        out_empty,
  input  logic                        out_pop,
  output mahp_pkg::mahp_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [mahp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mahp_pkg::CFG_DW-1:0] cfg_data
);
  import mahp_pkg::*;

  localparam int LW = $clog2(SIZE + 1);
  localparam int JW = 48 + LW;

  logic          clearing, q_push, q_full, q_pop, q_empty;
  logic [JW-1:0] q_wdata, q_rdata;

  mahp_front #(.SIZE(SIZE), .LW(LW), .JW(JW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .clearing(clearing),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  mahp_queue #(.W(JW)) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  mahp_back #(.SIZE(SIZE), .LW(LW), .JW(JW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

endmodule

// ===== src/mahp_checker.sv =====
// ----------------------------------------------------------------------------
// mahp_checker
// Port level checks of the filter: request accounting and result hold.
// ----------------------------------------------------------------------------
module mahp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input mahp_pkg::mahp_out_t out_data
);

  logic [2:0] cnt_r;
  logic       acc_in, acc_out;

  assign acc_in  = in_push && !in_full;
  assign acc_out = out_pop && !out_empty;

  // Requests inside the block: front, two queue slots, back, result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + {2'b00, acc_in} - {2'b00, acc_out};
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> out_empty && in_full)
    else $error("block not idle after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 3'd0 |-> out_empty)
    else $error("result shown without a pending request");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd5)
    else $error("more requests inside than the block can hold");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

endmodule

bind moving_average_highpass_filter mahp_checker u_mahp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_push  (in_push),
  .in_full  (in_full),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_data (out_data)
);
